@@ hdl/cbf_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package cbf_pkg;
    localparam int CoordW = 20;
    localparam int TolW = 16;

    typedef logic signed [CoordW-1:0] coord_t;

    typedef struct packed {
        coord_t [3:0] x;
        coord_t [3:0] y;
    } piece_t;

    typedef struct packed {
        logic load;
        logic test_start;
        logic split;
        logic pop;
    } cbf_cmd_t;

    typedef struct packed {
        logic test_done;
        logic is_flat;
        logic at_cap;
        logic stack_empty;
    } cbf_sts_t;

    function automatic coord_t half_sum(coord_t a, coord_t b);
        logic signed [CoordW:0] s;
        s = {a[CoordW-1], a} + {b[CoordW-1], b};
        return s[CoordW:1];
    endfunction
endpackage
`default_nettype wire

@@ hdl/cbf_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cbf_datapath #(
    parameter int MAX_DEPTH = 5
) (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire cbf_pkg::cbf_cmd_t          cmd,
    output cbf_pkg::cbf_sts_t               sts,
    input  wire cbf_pkg::piece_t            in_piece,
    input  wire logic [cbf_pkg::TolW-1:0]   tol,
    output cbf_pkg::coord_t                 start_x,
    output cbf_pkg::coord_t                 start_y
);
    localparam int StackD = MAX_DEPTH + 1;
    localparam int LvlW = $clog2(MAX_DEPTH + 1);
    localparam int SpW = $clog2(StackD + 1);

    cbf_pkg::piece_t cur_reg;
    logic [LvlW-1:0] lvl_reg;
    logic [SpW-1:0] sp_reg;
    cbf_pkg::piece_t stk_mem [StackD];
    logic [LvlW-1:0] lvl_mem [StackD];

    // flatness test sequencer
    logic [2:0] tst_reg;
    logic busy_reg;
    logic flat_reg;
    logic signed [20:0] dx_reg, dy_reg, qx_reg, qy_reg;
    logic signed [41:0] p1_reg, p2_reg;
    logic [42:0] len2_reg;
    logic [59:0] rhs_reg;
    logic [43:0] cr_abs_reg;
    logic [49:0] sq_reg;

    cbf_pkg::piece_t lo, hi;
    always_comb begin
        for (int c = 0; c < 2; c++) begin
            cbf_pkg::coord_t v0, v1, v2, v3, ab, bc, cd, abbc, bccd, e;
            v0 = c == 0 ? cur_reg.x[0] : cur_reg.y[0];
            v1 = c == 0 ? cur_reg.x[1] : cur_reg.y[1];
            v2 = c == 0 ? cur_reg.x[2] : cur_reg.y[2];
            v3 = c == 0 ? cur_reg.x[3] : cur_reg.y[3];
            ab = cbf_pkg::half_sum(v0, v1);
            bc = cbf_pkg::half_sum(v1, v2);
            cd = cbf_pkg::half_sum(v2, v3);
            abbc = cbf_pkg::half_sum(ab, bc);
            bccd = cbf_pkg::half_sum(bc, cd);
            e = cbf_pkg::half_sum(abbc, bccd);
            if (c == 0) begin
                lo.x = {e, abbc, ab, v0};
                hi.x = {v3, cd, bccd, e};
            end else begin
                lo.y = {e, abbc, ab, v0};
                hi.y = {v3, cd, bccd, e};
            end
        end
    end

    logic signed [43:0] cr;
    assign cr = 44'(p1_reg) - 44'(p2_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sp_reg <= '0;
            busy_reg <= 1'b0;
            tst_reg <= '0;
        end else begin
            if (cmd.load) begin
                cur_reg <= in_piece;
                lvl_reg <= '0;
                sp_reg <= '0;
            end else if (cmd.split) begin
                cur_reg <= lo;
                lvl_reg <= lvl_reg + 1'b1;
                stk_mem[sp_reg[$clog2(StackD)-1:0]] <= hi;
                lvl_mem[sp_reg[$clog2(StackD)-1:0]] <= lvl_reg + 1'b1;
                sp_reg <= sp_reg + 1'b1;
            end else if (cmd.pop) begin
                cur_reg <= stk_mem[sp_reg[$clog2(StackD)-1:0] - 1'b1];
                lvl_reg <= lvl_mem[sp_reg[$clog2(StackD)-1:0] - 1'b1];
                sp_reg <= sp_reg - 1'b1;
            end
            if (cmd.test_start) begin
                busy_reg <= 1'b1;
                tst_reg <= '0;
                flat_reg <= 1'b1;
            end else if (busy_reg) begin
                tst_reg <= tst_reg + 1'b1;
                if (tst_reg == 3'd7) busy_reg <= 1'b0;
            end
            unique case (tst_reg)
                3'd0: begin
                    dx_reg <= 21'(cur_reg.x[3]) - 21'(cur_reg.x[0]);
                    dy_reg <= 21'(cur_reg.y[3]) - 21'(cur_reg.y[0]);
                    qx_reg <= 21'(cur_reg.x[1]) - 21'(cur_reg.x[0]);
                    qy_reg <= 21'(cur_reg.y[1]) - 21'(cur_reg.y[0]);
                end
                3'd1: begin
                    p1_reg <= dx_reg * dx_reg;
                    p2_reg <= dy_reg * dy_reg;
                end
                3'd2: begin
                    len2_reg <= 43'(unsigned'(p1_reg)) + 43'(unsigned'(p2_reg));
                    p1_reg <= dx_reg * qy_reg;
                    p2_reg <= dy_reg * qx_reg;
                end
                3'd3: begin
                    rhs_reg <= 60'(tol) * 60'(len2_reg);
                    cr_abs_reg <= cr < 0 ? 44'(-cr) : 44'(cr);
                    qx_reg <= 21'(cur_reg.x[2]) - 21'(cur_reg.x[0]);
                    qy_reg <= 21'(cur_reg.y[2]) - 21'(cur_reg.y[0]);
                end
                3'd4: begin
                    sq_reg <= 50'(cr_abs_reg[24:0]) * 50'(cr_abs_reg[24:0]);
                    if (cr_abs_reg[43:25] != '0) flat_reg <= 1'b0;
                    p1_reg <= dx_reg * qy_reg;
                    p2_reg <= dy_reg * qx_reg;
                end
                3'd5: begin
                    if ({2'b00, sq_reg, 8'd0} > rhs_reg) flat_reg <= 1'b0;
                    cr_abs_reg <= cr < 0 ? 44'(-cr) : 44'(cr);
                end
                3'd6: begin
                    sq_reg <= 50'(cr_abs_reg[24:0]) * 50'(cr_abs_reg[24:0]);
                    if (cr_abs_reg[43:25] != '0) flat_reg <= 1'b0;
                end
                3'd7: begin
                    if (busy_reg && {2'b00, sq_reg, 8'd0} > rhs_reg) flat_reg <= 1'b0;
                end
                default: ;
            endcase
        end
    end

    always_comb begin
        sts.test_done = busy_reg && tst_reg == 3'd7 && !cmd.test_start;
        sts.is_flat = flat_reg && !({2'b00, sq_reg, 8'd0} > rhs_reg);
        sts.at_cap = lvl_reg >= LvlW'(MAX_DEPTH) || sp_reg >= SpW'(StackD);
        sts.stack_empty = sp_reg == '0;
    end
    assign start_x = cur_reg.x[0];
    assign start_y = cur_reg.y[0];
endmodule
`default_nettype wire

@@ hdl/cbf_ctrl.sv @@
`timescale 1ns / 1ps
`default_nettype none
module cbf_ctrl (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    output logic                   emit,
    output logic                   emit_last,
    input  wire logic              out_free,
    output cbf_pkg::cbf_cmd_t      cmd,
    input  wire cbf_pkg::cbf_sts_t sts
);
    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DECIDE = 3'd1;
    localparam logic [2:0] S_TEST = 3'd2;
    localparam logic [2:0] S_EMIT = 3'd3;
    localparam logic [2:0] S_END = 3'd4;

    logic [2:0] state_reg, state_next;

    always_comb begin
        state_next = state_reg;
        cmd = '0;
        emit = 1'b0;
        emit_last = 1'b0;
        s_tready = state_reg == S_IDLE;
        unique case (state_reg)
            S_IDLE: if (s_tvalid) begin
                cmd.load = 1'b1;
                state_next = S_DECIDE;
            end
            S_DECIDE: begin
                if (sts.at_cap) state_next = S_EMIT;
                else begin
                    cmd.test_start = 1'b1;
                    state_next = S_TEST;
                end
            end
            S_TEST: if (sts.test_done) begin
                if (sts.is_flat) state_next = S_EMIT;
                else begin
                    cmd.split = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_EMIT: if (out_free) begin
                emit = 1'b1;
                if (sts.stack_empty) state_next = S_END;
                else begin
                    cmd.pop = 1'b1;
                    state_next = S_DECIDE;
                end
            end
            S_END: if (out_free) begin
                emit = 1'b1;
                emit_last = 1'b1;
                state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= S_IDLE;
        else state_reg <= state_next;
    end
endmodule
`default_nettype wire

@@ hdl/cubic_bezier_flattener_unit.sv @@
// Cubic Bezier flattener.
// s_ channel: one curve per word (start, ctrl1, ctrl2, end points, x then y,
// each 20 bit signed Q16.4). m_ channel: polyline vertices, x and y in
// tdata, tlast marks the curve end point that closes the run.
// cfg channel: writes the 16 bit flatness tolerance (reset value 655).
// One curve is processed at a time; s_tready is high only when idle.
// Each tested piece takes a decide step plus a flatness test on
// shared multipliers; a piece at the depth cap takes only the decide step,
// and every vertex takes one more emit step.
// A one-word output register holds each vertex; while the receiver stalls
// the controller waits and no work is lost.
// Reset returns to idle, empties the output register and reloads the
// tolerance; the piece stack needs no clearing.
`timescale 1ns / 1ps
`default_nettype none
module cubic_bezier_flattener_unit #(
    parameter int MAX_DEPTH = 5
) (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // start_x, start_y, ctrl1_x, ctrl1_y, ctrl2_x, ctrl2_y, end_x, end_y
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // point_x, point_y
    output logic [39:0]       m_tdata,
    output logic              m_tlast,
    input  wire logic         cfg_valid,
    output logic              cfg_ready,
    input  wire logic [15:0]  cfg_data
);
    logic [15:0] tol_reg;
    cbf_pkg::piece_t in_piece, end_keep_reg;
    cbf_pkg::cbf_cmd_t cmd;
    cbf_pkg::cbf_sts_t sts;
    cbf_pkg::coord_t sx, sy;
    logic emit, emit_last, out_free;
    logic [39:0] m_tdata_reg;
    logic m_tvalid_reg, m_tlast_reg;

    always_comb begin
        for (int i = 0; i < 4; i++) begin
            in_piece.x[i] = s_tdata[40*i +: 20];
            in_piece.y[i] = s_tdata[40*i + 20 +: 20];
        end
    end

    assign cfg_ready = 1'b1;
    assign out_free = !m_tvalid_reg || m_tready;

    cbf_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .emit(emit), .emit_last(emit_last), .out_free(out_free),
        .cmd(cmd), .sts(sts)
    );

    cbf_datapath #(.MAX_DEPTH(MAX_DEPTH)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .sts(sts),
        .in_piece(in_piece), .tol(tol_reg), .start_x(sx), .start_y(sy)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tol_reg <= 16'd655;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cfg_valid) tol_reg <= cfg_data;
            if (cmd.load) end_keep_reg <= in_piece;
            if (emit) begin
                m_tvalid_reg <= 1'b1;
                m_tlast_reg <= emit_last;
                m_tdata_reg <= emit_last ? {end_keep_reg.y[3], end_keep_reg.x[3]}
                                         : {sy, sx};
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata = m_tdata_reg;
    assign m_tlast = m_tlast_reg;
endmodule
`default_nettype wire
